@@ src/assert_macros.svh @@
// assertion helpers, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define KMB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define KMB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/kmb_pkg.sv @@
package kmb_pkg;

	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_DIMS     = 16;
	localparam int MAX_BATCH    = 8192;
	localparam int FRAC_BITS    = 16;

	localparam int CL_W    = $clog2(MAX_CLUSTERS);
	localparam int DIM_W   = $clog2(MAX_DIMS);
	localparam int ADDR_W  = CL_W + DIM_W;
	localparam int DEPTH   = MAX_CLUSTERS * MAX_DIMS;
	localparam int REG_W   = 5;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 32;
	localparam int HITS_W  = $clog2(MAX_BATCH + 1);
	localparam int SUM_W   = 48;
	localparam int DIST_W  = 63;
	localparam int DVD_W   = 48;
	localparam int DEN_W   = 46;
	localparam int DIVC_W  = $clog2(DVD_W);

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	typedef logic [DIST_W-1:0] dist_t;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_TRAIN    = 2'd1,
		OP_CLASSIFY = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	localparam logic CFG_NUM_CLUSTERS = 1'b0;
	localparam logic CFG_NUM_DIMS     = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ELEM,
		S_REPORT,
		S_SUMRD,
		S_SUMWR,
		S_CLHIT,
		S_CLRD,
		S_CLDAT,
		S_CLMUL,
		S_CLNUM,
		S_CLDIV,
		S_CLWR,
		S_CLCNT,
		S_CLEND
	} state_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] r,
			input logic [REG_W-1:0] mx);
		if (r == '0)
			return REG_W'(1);
		if (r > mx)
			return mx;
		return r;
	endfunction

endpackage

@@ src/kmb_if.sv @@
interface kmb_in_if;
	import kmb_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              opcode;
	logic [CL_W-1:0]         cluster_index;
	logic [DIM_W-1:0]        dim_index;
	logic signed [VAL_W-1:0] sample_value;
	logic [CNT_W-1:0]        initial_count;
	logic                    last_of_batch;
	modport source(output valid, opcode, cluster_index, dim_index, sample_value,
		initial_count, last_of_batch, input ready);
	modport sink(input valid, opcode, cluster_index, dim_index, sample_value,
		initial_count, last_of_batch, output ready);
endinterface

interface kmb_out_if;
	import kmb_pkg::*;
	logic              valid;
	logic              ready;
	logic [CL_W-1:0]   assigned_cluster;
	logic [DIST_W-1:0] distance_sq;
	logic              from_training;
	modport source(output valid, assigned_cluster, distance_sq, from_training,
		input ready);
	modport sink(input valid, assigned_cluster, distance_sq, from_training,
		output ready);
endinterface

@@ src/kmb_cell.sv @@
module kmb_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  kmb_pkg::cell_ctrl_t ctrl,
	input  kmb_pkg::dist_t     in_dist,
	input  kmb_pkg::dist_t     term,
	output kmb_pkg::dist_t     run_q,
	output kmb_pkg::dist_t     nxt
);
	import kmb_pkg::*;

	logic [DIST_W:0] sum;

	assign sum = {1'b0, in_dist} + {1'b0, term};
	assign nxt = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (ctrl.clear) begin
			run_q <= '0;
		end else if (ctrl.shift) begin
			run_q <= nxt;
		end
	end
endmodule

@@ src/kmb_divider.sv @@
module kmb_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [kmb_pkg::DVD_W-1:0] dividend,
	input  logic [kmb_pkg::DEN_W-1:0] divisor,
	output logic                      done,
	output logic [kmb_pkg::DVD_W-1:0] quotient
);
	import kmb_pkg::*;

	logic              busy_q;
	logic [DIVC_W-1:0] cnt_q;
	logic [DEN_W:0]    rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DEN_W-1:0]  dvs_q;
	logic [DEN_W:0]    trial;
	logic              ge;

	assign trial    = {rem_q[DEN_W-1:0], quo_q[DVD_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIVC_W'(1);
			if (cnt_q == DIVC_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end else begin
			done <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end
endmodule

@@ src/mini_batch_kmeans_engine.sv @@
// Mini-batch k-means engine: up to 16 centroids of up to 16 Q16.16 dimensions. A load item
// is written to the centroid memory as it is accepted. For a point element the 16 centroid
// reads go one a cycle through the single read port of the centroid memory and three
// pipeline stages into a ring of 16 distance cells; no new item is accepted meanwhile.
// A completed point posts its result in S_REPORT (held while the previous result is still
// untaken) and, for a training point with room in its cluster, updates the batch sums.
// A batch close steps through every cluster: one hit in the batch runs S_CLRD to S_CLWR per
// dimension, waiting on the bit-serial divider, and S_CLCNT; S_CLEND clears the batch.
`include "assert_macros.svh"

module mini_batch_kmeans_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	kmb_in_if.sink                    samples,
	kmb_out_if.source                 results,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [kmb_pkg::REG_W-1:0] cfg_wdata
);
	import kmb_pkg::*;

	state_t state_q, state_d;

	logic [REG_W-1:0] num_clusters_q, num_dims_q, k_act, dims_act;

	logic [VAL_W-1:0]  cent_mem [DEPTH];
	logic [SUM_W-1:0]  bs_mem [DEPTH];
	logic [DEPTH-1:0]  bs_vld_q;
	logic [CNT_W-1:0]  seen_q [MAX_CLUSTERS];
	logic [HITS_W-1:0] hits_q [MAX_CLUSTERS];
	logic [VAL_W-1:0]  pb_q [MAX_DIMS];

	logic              cent_we;
	logic [ADDR_W-1:0] cent_wa, cent_ra;
	logic [VAL_W-1:0]  cent_wd, cent_rd_q;
	logic              bs_we;
	logic [ADDR_W-1:0] bs_wa, bs_ra;
	logic [SUM_W-1:0]  bs_wd, bs_rd_q;
	logic              bsv_rd_q;

	logic             acc;
	logic             op_train_q, lob_q, last_q;
	logic [DIM_W-1:0] di_q, jj_q;
	logic [VAL_W-1:0] val_q;
	logic [CL_W:0]    ic_q;
	logic [CL_W-1:0]  cc_q, best_q;
	dist_t            bd_q;

	logic            v_s1, v_s2, v_s3;
	logic [CL_W-1:0] c_s1, c_s2, c_s3;
	logic [VAL_W:0]  mag_s2, diff_c;
	dist_t           sq_s3;
	logic [2*VAL_W+1:0] sq_full;
	logic            elem_end;

	cell_ctrl_t cell_ctrl;
	dist_t      cell_dist [MAX_CLUSTERS];
	dist_t      cell_nxt [MAX_CLUSTERS];

	logic                    out_valid_q;
	logic [CL_W-1:0]         out_cl_q;
	dist_t                   out_d_q;
	logic                    out_tr_q;

	logic [HITS_W-1:0]       hits_cur_q;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W:0]          den_full;
	logic signed [VAL_W-1:0] cur_q;
	logic [SUM_W-1:0]        sum_q;
	logic signed [46:0]      prod_c, prod_q;
	logic [SUM_W:0]          num_c;
	logic [DVD_W-1:0]        mag_c, dvd_c;
	logic                    neg_q;
	logic                    div_start, div_done;
	logic [DVD_W-1:0]        div_quo;
	logic [DVD_W+1:0]        nv_w;
	logic [VAL_W-1:0]        nv;
	logic [CNT_W:0]          cnt_sum;
	logic                    room;
	logic                    dims_last;

	assign k_act    = clamp_reg(num_clusters_q, REG_W'(MAX_CLUSTERS));
	assign dims_act = clamp_reg(num_dims_q, REG_W'(MAX_DIMS));
	assign acc      = samples.valid && samples.ready;
	assign samples.ready = (state_q == S_IDLE);
	assign room      = hits_q[best_q] < HITS_W'(MAX_BATCH);
	assign dims_last = ({1'b0, jj_q} == dims_act - REG_W'(1));
	assign elem_end  = v_s3 && (c_s3 == CL_W'(MAX_CLUSTERS - 1));

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= REG_W'(1);
			num_dims_q     <= REG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_CLUSTERS: num_clusters_q <= cfg_wdata;
				CFG_NUM_DIMS:     num_dims_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && (samples.opcode == OP_TRAIN || samples.opcode == OP_CLASSIFY)
						&& ({1'b0, samples.dim_index} < dims_act))
					state_d = S_ELEM;
			end
			S_ELEM: begin
				if (elem_end)
					state_d = last_q ? S_REPORT : ((op_train_q && lob_q) ? S_CLHIT : S_IDLE);
			end
			S_REPORT: begin
				if (!out_valid_q) begin
					if (op_train_q && room)
						state_d = S_SUMRD;
					else
						state_d = (op_train_q && lob_q) ? S_CLHIT : S_IDLE;
				end
			end
			S_SUMRD: state_d = S_SUMWR;
			S_SUMWR: begin
				if (dims_last)
					state_d = lob_q ? S_CLHIT : S_IDLE;
				else
					state_d = S_SUMRD;
			end
			S_CLHIT: begin
				if (hits_q[cc_q] != '0)
					state_d = S_CLRD;
				else if (cc_q == CL_W'(MAX_CLUSTERS - 1))
					state_d = S_CLEND;
			end
			S_CLRD:  state_d = S_CLDAT;
			S_CLDAT: state_d = S_CLMUL;
			S_CLMUL: state_d = S_CLNUM;
			S_CLNUM: state_d = S_CLDIV;
			S_CLDIV: if (div_done) state_d = S_CLWR;
			S_CLWR:  state_d = dims_last ? S_CLCNT : S_CLRD;
			S_CLCNT: state_d = (cc_q == CL_W'(MAX_CLUSTERS - 1)) ? S_CLEND : S_CLHIT;
			S_CLEND: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cent_we   = 1'b0;
		cent_wa   = {samples.cluster_index, samples.dim_index};
		cent_wd   = samples.sample_value;
		cent_ra   = {cc_q, jj_q};
		bs_we     = 1'b0;
		bs_wa     = {best_q, jj_q};
		bs_ra     = {best_q, jj_q};
		div_start = 1'b0;
		cell_ctrl = '{shift: v_s3, clear: 1'b0};
		unique case (state_q)
			S_IDLE:   cent_we = acc && (samples.opcode == OP_LOAD);
			S_ELEM:   cent_ra = {ic_q[CL_W-1:0], di_q};
			S_REPORT: cell_ctrl.clear = !out_valid_q;
			S_SUMWR:  bs_we = 1'b1;
			S_CLRD:   bs_ra = {cc_q, jj_q};
			S_CLNUM:  div_start = 1'b1;
			S_CLWR: begin
				cent_we = 1'b1;
				cent_wa = {cc_q, jj_q};
				cent_wd = nv;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// memories
	always_ff @(posedge clk) begin
		if (cent_we)
			cent_mem[cent_wa] <= cent_wd;
		cent_rd_q <= cent_mem[cent_ra];
	end

	assign bs_wd = (bsv_rd_q ? bs_rd_q : '0) + {{(SUM_W - VAL_W){pb_q[jj_q][VAL_W-1]}}, pb_q[jj_q]};

	always_ff @(posedge clk) begin
		if (bs_we)
			bs_mem[bs_wa] <= bs_wd;
		bs_rd_q <= bs_mem[bs_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bsv_rd_q <= 1'b0;
		else
			bsv_rd_q <= bs_vld_q[bs_ra];
	end

	// distance pipeline
	assign diff_c  = {val_q[VAL_W-1], val_q} - {cent_rd_q[VAL_W-1], cent_rd_q};
	assign sq_full = mag_s2 * mag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ic_q <= '0;
		end else begin
			v_s1 <= (state_q == S_ELEM) && !ic_q[CL_W];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (state_q == S_ELEM)
				ic_q <= ic_q[CL_W] ? ic_q : ic_q + (CL_W + 1)'(1);
			else
				ic_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		c_s1   <= ic_q[CL_W-1:0];
		c_s2   <= c_s1;
		c_s3   <= c_s2;
		mag_s2 <= diff_c[VAL_W] ? -diff_c : diff_c;
		sq_s3  <= (|sq_full[2*VAL_W+1:DIST_W]) ? DIST_MAX : sq_full[DIST_W-1:0];
	end

	// ring of distance cells, rotating once per centroid
	for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
		kmb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl),
			.in_dist ((i == MAX_CLUSTERS - 1) ? cell_dist[0] : cell_dist[(i + 1) % MAX_CLUSTERS]),
			.term    ((i == MAX_CLUSTERS - 1) ? sq_s3 : '0),
			.run_q   (cell_dist[i]),
			.nxt     (cell_nxt[i])
		);
	end

	// item capture, point buffer, nearest search, batch bookkeeping
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc) begin
			op_train_q <= (samples.opcode == OP_TRAIN);
			lob_q      <= samples.last_of_batch;
			di_q       <= samples.dim_index;
			val_q      <= samples.sample_value;
			last_q     <= ({1'b0, samples.dim_index} == dims_act - REG_W'(1));
			if (samples.opcode == OP_LOAD)
				seen_q[samples.cluster_index] <= samples.initial_count;
			else if ((samples.opcode == OP_TRAIN || samples.opcode == OP_CLASSIFY)
					&& ({1'b0, samples.dim_index} < dims_act))
				pb_q[samples.dim_index] <= samples.sample_value;
		end
		if (v_s3 && last_q) begin
			if (c_s3 == '0 || ({1'b0, c_s3} < k_act && cell_nxt[MAX_CLUSTERS-1] < bd_q)) begin
				best_q <= c_s3;
				bd_q   <= cell_nxt[MAX_CLUSTERS-1];
			end
		end
		if (state_q == S_CLDAT) begin
			cur_q <= cent_rd_q;
			sum_q <= bsv_rd_q ? bs_rd_q : '0;
		end
		if (state_q == S_CLHIT) begin
			hits_cur_q <= hits_q[cc_q];
			den_q      <= den_full[DEN_W-1:0];
		end
		if (state_q == S_CLMUL)
			prod_q <= prod_c;
		if (state_q == S_CLNUM)
			neg_q <= num_c[SUM_W];
		if (state_q == S_CLCNT)
			seen_q[cc_q] <= cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jj_q     <= '0;
			cc_q     <= '0;
			bs_vld_q <= '0;
			for (int c = 0; c < MAX_CLUSTERS; c++)
				hits_q[c] <= '0;
		end else begin
			unique case (state_q)
				S_ELEM: begin
					jj_q <= '0;
					cc_q <= '0;
				end
				S_REPORT: jj_q <= '0;
				S_SUMWR: begin
					bs_vld_q[{best_q, jj_q}] <= 1'b1;
					jj_q <= jj_q + DIM_W'(1);
					if (dims_last) begin
						hits_q[best_q] <= hits_q[best_q] + HITS_W'(1);
						jj_q <= '0;
					end
				end
				S_CLHIT: begin
					jj_q <= '0;
					if (hits_q[cc_q] == '0)
						cc_q <= cc_q + CL_W'(1);
				end
				S_CLWR: jj_q <= jj_q + DIM_W'(1);
				S_CLCNT: cc_q <= cc_q + CL_W'(1);
				S_CLEND: begin
					bs_vld_q <= '0;
					for (int c = 0; c < MAX_CLUSTERS; c++)
						hits_q[c] <= '0;
				end
				default: ;
			endcase
		end
	end

	// blend arithmetic
	assign den_full = (DEN_W + 1)'(hits_q[cc_q]) * (DEN_W + 1)'({1'b0, seen_q[cc_q]} + 33'd1);
	assign prod_c   = $signed({1'b0, hits_cur_q}) * cur_q;
	assign num_c    = {sum_q[SUM_W-1], sum_q} - {{2{prod_q[46]}}, prod_q};
	assign mag_c    = num_c[SUM_W] ? DVD_W'(-num_c) : num_c[DVD_W-1:0];
	assign dvd_c    = mag_c + DVD_W'(den_q[DEN_W-1:1]);
	assign nv_w     = neg_q ? ({{(DVD_W + 2 - VAL_W){cur_q[VAL_W-1]}}, cur_q} - {2'b0, div_quo})
	                        : ({{(DVD_W + 2 - VAL_W){cur_q[VAL_W-1]}}, cur_q} + {2'b0, div_quo});
	assign cnt_sum  = {1'b0, seen_q[cc_q]} + (CNT_W + 1)'(hits_cur_q);

	always_comb begin
		if (!nv_w[DVD_W+1] && (|nv_w[DVD_W:VAL_W-1]))
			nv = {1'b0, {(VAL_W - 1){1'b1}}};
		else if (nv_w[DVD_W+1] && !(&nv_w[DVD_W:VAL_W-1]))
			nv = {1'b1, {(VAL_W - 1){1'b0}}};
		else
			nv = nv_w[VAL_W-1:0];
	end

	kmb_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_c),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_REPORT && !out_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REPORT && !out_valid_q) begin
			out_cl_q <= best_q;
			out_d_q  <= bd_q;
			out_tr_q <= op_train_q;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.assigned_cluster = out_cl_q;
	assign results.distance_sq      = out_d_q;
	assign results.from_training    = out_tr_q;

	`KMB_ASSERT_NEXT(a_div_not_instant, div_start, !div_done, "divider finished at once")
	`KMB_ASSERT(a_sum_after_read, (state_q == S_SUMWR) |-> ($past(state_q) == S_SUMRD), "no read")
	`KMB_ASSERT(a_hits_room, (state_q == S_SUMRD) |-> (hits_q[best_q] < HITS_W'(MAX_BATCH)), "hits")
endmodule
